>>> hw/rtl/lcrt_pkg.sv
// ---------------------------------------------------------------------------
// lcrt_pkg
// Shared types, constants and helpers of the log chunk reassembly tracker.
// ---------------------------------------------------------------------------
package lcrt_pkg;

   localparam int BINS_PER_CHUNK = 512;
   localparam int BIN_BYTES      = 90;
   localparam int CHUNK_BYTES    = BINS_PER_CHUNK * BIN_BYTES;

   localparam int BIN_W    = $clog2(BINS_PER_CHUNK);
   localparam int NBIN_W   = BIN_W + 1;
   localparam int WORD_W   = 32;
   localparam int BITSEL_W = $clog2(WORD_W);
   localparam int WORDS    = BINS_PER_CHUNK / WORD_W;
   localparam int WADDR_W  = BIN_W - BITSEL_W;
   localparam int CHUNK_W  = 17;
   localparam int BASE_W   = 33;

   // reciprocals for division by the bin size
   localparam int RECIP_BIN_SH   = 22;
   localparam int RECIP_BIN      = (2 ** RECIP_BIN_SH + BIN_BYTES - 1) / BIN_BYTES;
   localparam int RECIP_CHUNK_SH = 30;
   localparam int RECIP_CHUNK    = (2 ** RECIP_CHUNK_SH + BIN_BYTES - 1) / BIN_BYTES;

   localparam logic [1:0] CMD_START  = 2'd0;
   localparam logic [1:0] CMD_DATA   = 2'd1;
   localparam logic [1:0] CMD_TICK   = 2'd2;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_BAD_ID   = 3'd1;
   localparam logic [2:0] ST_MISALIGN = 3'd2;
   localparam logic [2:0] ST_BAD_CHNK = 3'd3;
   localparam logic [2:0] ST_BEYOND   = 3'd4;
   localparam logic [2:0] ST_BIN_OOR  = 3'd5;
   localparam logic [2:0] ST_OTHER    = 3'd6;

   localparam logic [1:0] REG_LOG_SIZE = 2'd0;
   localparam logic [1:0] REG_LOG_ID   = 2'd1;
   localparam logic [1:0] REG_ID_BASE  = 2'd2;

   typedef struct packed {
      logic [1:0]         cmd;
      logic               id_bad;
      logic               misaligned;
      logic               beyond;
      logic [CHUNK_W-1:0] chunk;
      logic [BIN_W-1:0]   bin;
      logic [6:0]         count;
   } lcrt_item_type;

   typedef struct packed {
      logic [2:0]  status;
      logic        req_valid;
      logic [15:0] req_log_id;
      logic [31:0] req_offset;
      logic [15:0] req_length;
      logic [7:0]  req_retries;
      logic        done_res;
      logic [31:0] bytes_written;
   } lcrt_result_type;

   // index of the lowest set bit
   function automatic logic [BITSEL_W-1:0] lowest_set(input logic [WORD_W-1:0] v);
      logic [BITSEL_W-1:0] idx;
      idx = '0;
      for (int i = WORD_W - 1; i >= 0; i--) begin
         if (v[i]) begin
            idx = BITSEL_W'(i);
         end
      end
      return idx;
   endfunction

endpackage

>>> hw/rtl/lcrt_front.sv
// ---------------------------------------------------------------------------
// lcrt_front
// Takes input words and classifies packets: id, alignment, size, chunk, bin.
// ---------------------------------------------------------------------------
module lcrt_front
   import lcrt_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   output logic          in_ready,
   input  logic [1:0]    in_cmd,
   input  logic [31:0]   in_offset,
   input  logic [15:0]   in_log_id,
   input  logic [6:0]    in_count,
   input  logic [31:0]   log_size,
   input  logic [15:0]   log_id,
   input  logic          id_base,
   output logic          out_valid,
   input  logic          out_ready,
   output lcrt_item_type out_item
);

   logic               busy_ff, busy_in;
   logic [2:0]         step_ff, step_in;
   logic [1:0]         cmd_ff;
   logic [31:0]        offs_ff;
   logic [15:0]        pid_ff;
   logic [6:0]         cnt_ff;
   logic [46:0]        p1_ff;
   logic [CHUNK_W-1:0] chunk_ff;
   logic [BASE_W-1:0]  p2_ff;
   logic [15:0]        r_ff;
   logic [31:0]        p3_ff;
   logic [31:0]        r_full;
   logic [BIN_W-1:0]   bin_w;
   logic               take;

   assign in_ready = !busy_ff;
   assign take     = in_valid && !busy_ff;
   assign out_valid = busy_ff && (step_ff == 3'd4);

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      if (take) begin
         busy_in = 1'b1;
         step_in = '0;
      end else if (busy_ff) begin
         if (step_ff != 3'd4) begin
            step_in = step_ff + 3'd1;
         end else if (out_ready) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
   end

   // offset / chunk size = (offset >> 9) / bin size, then bin and remainder
   assign r_full = offs_ff - p2_ff[31:0];
   assign bin_w  = p3_ff[RECIP_BIN_SH+BIN_W-1:RECIP_BIN_SH];

   always_ff @(posedge clock) begin
      if (take) begin
         cmd_ff  <= in_cmd;
         offs_ff <= in_offset;
         pid_ff  <= in_log_id;
         cnt_ff  <= in_count;
      end
      p1_ff    <= 47'(offs_ff[31:9]) * 47'(RECIP_CHUNK);
      chunk_ff <= p1_ff[RECIP_CHUNK_SH+CHUNK_W-1:RECIP_CHUNK_SH];
      p2_ff    <= BASE_W'(chunk_ff) * BASE_W'(CHUNK_BYTES);
      r_ff     <= r_full[15:0];
      p3_ff    <= 32'(r_full[15:0]) * 32'(RECIP_BIN);
   end

   always_comb begin
      out_item.cmd        = cmd_ff;
      out_item.id_bad     = (pid_ff - 16'(id_base)) != log_id;
      out_item.misaligned = r_ff != (16'(bin_w) * 16'(BIN_BYTES));
      out_item.beyond     = offs_ff > log_size;
      out_item.chunk      = chunk_ff;
      out_item.bin        = bin_w;
      out_item.count      = cnt_ff;
   end

endmodule

>>> hw/rtl/lcrt_queue.sv
// ---------------------------------------------------------------------------
// lcrt_queue
// Two-entry queue of classified words between the front and the back.
// ---------------------------------------------------------------------------
module lcrt_queue
   import lcrt_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push_valid,
   output logic          push_ready,
   input  lcrt_item_type push_item,
   output logic          pop_valid,
   input  logic          pop_ready,
   output lcrt_item_type pop_item
);

   lcrt_item_type slot_ff [2];
   logic          wr_ptr_ff, rd_ptr_ff;
   logic [1:0]    fill_ff;
   logic          do_push, do_pop;

   assign push_ready = fill_ff != 2'd2;
   assign pop_valid  = fill_ff != 2'd0;
   assign pop_item   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= !wr_ptr_ff;
         if (do_pop) rd_ptr_ff <= !rd_ptr_ff;
         fill_ff <= fill_ff + 2'(do_push) - 2'(do_pop);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ptr_ff] <= push_item;
   end

endmodule

>>> hw/rtl/lcrt_back.sv
// ---------------------------------------------------------------------------
// lcrt_back
// Sequencer that owns the bin map, the chunk state and the request logic.
// ---------------------------------------------------------------------------
module lcrt_back
   import lcrt_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   output logic            in_ready,
   input  lcrt_item_type   in_item,
   input  logic [31:0]     log_size,
   input  logic [15:0]     log_id,
   input  logic            id_base,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output lcrt_result_type rsp
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_MARK  = 3'd1;
   localparam logic [2:0] S_CHECK = 3'd2;
   localparam logic [2:0] S_GAP   = 3'd3;
   localparam logic [2:0] S_BINS  = 3'd4;
   localparam logic [2:0] S_SIZE  = 3'd5;
   localparam logic [2:0] S_SCAN  = 3'd6;
   localparam logic [2:0] S_OUT   = 3'd7;

   localparam logic [1:0] AFTER_START = 2'd0;
   localparam logic [1:0] AFTER_CHUNK = 2'd1;
   localparam logic [1:0] AFTER_SCAN  = 2'd2;

   logic [2:0]          state_ff, state_in;
   logic [1:0]          after_ff, after_in;
   lcrt_item_type       item_ff, item_in;
   logic [CHUNK_W-1:0]  chunk_index_ff, chunk_index_in;
   logic [BASE_W-1:0]   base_ff, base_in;
   logic [NBIN_W-1:0]   bins_ff, bins_in;
   logic [NBIN_W-1:0]   set_count_ff, set_count_in;
   logic [7:0]          retry_ff, retry_in;
   logic [31:0]         bytes_ff, bytes_in;
   logic                finished_ff, finished_in;
   logic [WORDS-1:0]    word_vld_ff, word_vld_in;
   logic [WADDR_W-1:0]  scan_w_ff, scan_w_in;
   logic                phase_ff, phase_in;
   logic [NBIN_W-1:0]   first_ff, first_in;
   logic [31:0]         prod_ff;
   logic                le_ff, big_ff;
   lcrt_result_type     res_ff, res_in;
   lcrt_result_type     out_ff;
   logic                out_valid_ff, out_valid_in;
   logic                out_load;

   logic [WORD_W-1:0]   mem_ff [WORDS];
   logic [WORD_W-1:0]   rd_data_ff;
   logic                rd_vld_ff;
   logic                rd_en, wr_en;
   logic [WADDR_W-1:0]  rd_addr, wr_addr;
   logic [WORD_W-1:0]   wr_data, rd_word;

   logic [BASE_W-1:0]   size_x, rem, next_base;
   logic [15:0]         req_id;
   logic                full, last_chunk, done_now;
   logic [NBIN_W-1:0]   bins_val, bin1;
   logic                in_range;
   logic [WORD_W-1:0]   end_m, a_v, b_all, b0, above;
   logic [BITSEL_W-1:0] fa, fb0, fb1;
   logic [NBIN_W-1:0]   scan_base, cur_first, last_val, last_fin;
   logic                found_a, last_hit;

   assign rd_word   = rd_vld_ff ? rd_data_ff : '0;
   assign size_x    = BASE_W'(log_size);
   assign rem       = size_x - base_ff;
   assign full      = set_count_ff == bins_ff;
   assign last_chunk = (base_ff < size_x) && (size_x <= base_ff + BASE_W'(CHUNK_BYTES));
   assign done_now  = full && last_chunk;
   assign next_base = (chunk_index_ff == '1) ? '0 : base_ff + BASE_W'(CHUNK_BYTES);
   assign req_id    = log_id + 16'(id_base);
   assign bins_val  = le_ff ? '0 :
                      big_ff ? NBIN_W'(BINS_PER_CHUNK) :
                      prod_ff[RECIP_BIN_SH+NBIN_W-1:RECIP_BIN_SH];
   assign in_range  = NBIN_W'(item_ff.bin) < bins_ff;
   assign bin1      = NBIN_W'(item_ff.bin) + NBIN_W'(1);

   // word-wise gap search: bins past the chunk's end stop both searches
   assign scan_base = {1'b0, scan_w_ff, BITSEL_W'(0)};
   always_comb begin
      for (int j = 0; j < WORD_W; j++) begin
         end_m[j] = (scan_base + NBIN_W'(j)) >= bins_ff;
      end
   end
   assign a_v     = ~rd_word | end_m;
   assign b_all   = rd_word | end_m;
   assign fa      = lowest_set(a_v);
   assign found_a = |a_v;
   // the gap's own bit counts only when it is the chunk's end
   assign above   = ~(WORD_W'((33'd1 << fa) - 33'd1));
   assign b0      = b_all & above;
   assign fb0     = lowest_set(b0);
   assign fb1     = lowest_set(b_all);
   assign cur_first = phase_ff ? first_ff :
                      found_a ? scan_base + NBIN_W'(fa) : NBIN_W'(BINS_PER_CHUNK);
   assign last_hit  = phase_ff ? |b_all : (found_a && |b0);
   assign last_val  = scan_base + NBIN_W'(phase_ff ? fb1 : fb0);
   assign last_fin  = last_hit ? last_val : NBIN_W'(BINS_PER_CHUNK);

   assign in_ready  = state_ff == S_IDLE;
   assign out_load  = (state_ff == S_OUT) && (!out_valid_ff || rsp_ready);
   assign rsp_valid = out_valid_ff;
   assign rsp       = out_ff;

   always_comb begin
      state_in       = state_ff;
      after_in       = after_ff;
      item_in        = item_ff;
      chunk_index_in = chunk_index_ff;
      base_in        = base_ff;
      bins_in        = bins_ff;
      set_count_in   = set_count_ff;
      retry_in       = retry_ff;
      bytes_in       = bytes_ff;
      finished_in    = finished_ff;
      word_vld_in    = word_vld_ff;
      scan_w_in      = scan_w_ff;
      phase_in       = phase_ff;
      first_in       = first_ff;
      res_in         = res_ff;
      rd_en          = 1'b0;
      rd_addr        = '0;
      wr_en          = 1'b0;
      wr_addr        = item_ff.bin[BIN_W-1:BITSEL_W];
      wr_data        = rd_word | (WORD_W'(1) << item_ff.bin[BITSEL_W-1:0]);
      out_valid_in   = out_valid_ff && !rsp_ready;

      unique case (state_ff)
         S_IDLE: begin
            if (in_valid) begin
               item_in = in_item;
               res_in  = '0;
               res_in.status = ST_OTHER;
               if (in_item.cmd == CMD_START) begin
                  word_vld_in    = '0;
                  chunk_index_in = '0;
                  base_in        = '0;
                  retry_in       = '0;
                  bytes_in       = '0;
                  set_count_in   = '0;
                  after_in       = AFTER_START;
                  state_in       = S_BINS;
               end else if (finished_ff || in_item.cmd == CMD_UNUSED) begin
                  state_in = S_OUT;
               end else if (in_item.cmd == CMD_TICK) begin
                  state_in = S_GAP;
               end else if (in_item.id_bad) begin
                  res_in.status = ST_BAD_ID;
                  state_in      = S_OUT;
               end else if (in_item.misaligned) begin
                  res_in.status = ST_MISALIGN;
                  state_in      = S_OUT;
               end else if (in_item.beyond) begin
                  res_in.status = ST_BEYOND;
                  state_in      = S_OUT;
               end else if (in_item.chunk != chunk_index_ff) begin
                  res_in.status = ST_BAD_CHNK;
                  state_in      = S_OUT;
               end else begin
                  res_in.status = (NBIN_W'(in_item.bin) < bins_ff) ? ST_OK : ST_BIN_OOR;
                  bytes_in = bytes_ff + 32'(in_item.count);
                  retry_in = '0;
                  rd_en    = 1'b1;
                  rd_addr  = in_item.bin[BIN_W-1:BITSEL_W];
                  state_in = S_MARK;
               end
            end
         end
         S_MARK: begin
            if (in_range && !rd_word[item_ff.bin[BITSEL_W-1:0]]) begin
               wr_en = 1'b1;
               word_vld_in[item_ff.bin[BIN_W-1:BITSEL_W]] = 1'b1;
               set_count_in = set_count_ff + NBIN_W'(1);
            end
            // following bin; its bit is untouched by the write above
            rd_en    = 1'b1;
            rd_addr  = bin1[BIN_W-1:BITSEL_W];
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (done_now) begin
               finished_in = 1'b1;
               state_in    = S_OUT;
            end else if (full) begin
               chunk_index_in = chunk_index_ff + CHUNK_W'(1);
               base_in        = next_base;
               word_vld_in    = '0;
               set_count_in   = '0;
               after_in       = AFTER_CHUNK;
               state_in       = S_BINS;
            end else if ((bin1 < bins_ff) && rd_word[bin1[BITSEL_W-1:0]]) begin
               state_in = S_GAP;
            end else begin
               state_in = S_OUT;
            end
         end
         S_GAP: begin
            if (done_now) begin
               finished_in = 1'b1;
               state_in    = S_OUT;
            end else if (full) begin
               chunk_index_in = chunk_index_ff + CHUNK_W'(1);
               base_in        = next_base;
               word_vld_in    = '0;
               set_count_in   = '0;
               after_in       = AFTER_SCAN;
               state_in       = S_BINS;
            end else begin
               retry_in  = (retry_ff != 8'hFF) ? retry_ff + 8'd1 : retry_ff;
               rd_en     = 1'b1;
               scan_w_in = '0;
               phase_in  = 1'b0;
               state_in  = S_SCAN;
            end
         end
         S_BINS: begin
            state_in = S_SIZE;
         end
         S_SIZE: begin
            bins_in  = bins_val;
            state_in = S_OUT;
            unique case (after_ff)
               AFTER_START: begin
                  if (log_size == '0) begin
                     finished_in = 1'b1;
                  end else begin
                     finished_in       = 1'b0;
                     res_in.req_valid  = 1'b1;
                     res_in.req_log_id = req_id;
                     res_in.req_offset = '0;
                     res_in.req_length = 16'(32'(bins_val) * 32'(BIN_BYTES));
                  end
               end
               AFTER_CHUNK: begin
                  res_in.req_valid  = 1'b1;
                  res_in.req_log_id = req_id;
                  res_in.req_offset = base_ff[31:0];
                  res_in.req_length = 16'(32'(bins_val) * 32'(BIN_BYTES));
               end
               AFTER_SCAN: begin
                  retry_in  = (retry_ff != 8'hFF) ? retry_ff + 8'd1 : retry_ff;
                  rd_en     = 1'b1;
                  scan_w_in = '0;
                  phase_in  = 1'b0;
                  state_in  = S_SCAN;
               end
               default: begin
                  state_in = S_OUT;
               end
            endcase
         end
         S_SCAN: begin
            if (last_hit || scan_w_ff == WADDR_W'(WORDS - 1)) begin
               res_in.req_valid   = 1'b1;
               res_in.req_log_id  = req_id;
               res_in.req_offset  = base_ff[31:0] + 32'(cur_first) * 32'(BIN_BYTES);
               res_in.req_length  = 16'(32'(last_fin - cur_first) * 32'(BIN_BYTES));
               res_in.req_retries = retry_ff;
               state_in           = S_OUT;
            end else begin
               phase_in  = phase_ff | found_a;
               first_in  = cur_first;
               scan_w_in = scan_w_ff + WADDR_W'(1);
               rd_en     = 1'b1;
               rd_addr   = scan_w_ff + WADDR_W'(1);
            end
         end
         S_OUT: begin
            if (out_load) begin
               out_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         after_ff       <= AFTER_START;
         chunk_index_ff <= '0;
         base_ff        <= '0;
         bins_ff        <= '0;
         set_count_ff   <= '0;
         retry_ff       <= '0;
         bytes_ff       <= '0;
         finished_ff    <= 1'b1;
         word_vld_ff    <= '0;
         out_valid_ff   <= 1'b0;
         scan_w_ff      <= '0;
         phase_ff       <= 1'b0;
      end else begin
         state_ff       <= state_in;
         after_ff       <= after_in;
         chunk_index_ff <= chunk_index_in;
         base_ff        <= base_in;
         bins_ff        <= bins_in;
         set_count_ff   <= set_count_in;
         retry_ff       <= retry_in;
         bytes_ff       <= bytes_in;
         finished_ff    <= finished_in;
         word_vld_ff    <= word_vld_in;
         out_valid_ff   <= out_valid_in;
         scan_w_ff      <= scan_w_in;
         phase_ff       <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff  <= item_in;
      first_ff <= first_in;
      res_ff   <= res_in;
      // bins of the chunk: ceil(remaining / bin size) via reciprocal
      prod_ff  <= 32'(rem[15:0] + 16'(BIN_BYTES - 1)) * 32'(RECIP_BIN);
      le_ff    <= size_x <= base_ff;
      big_ff   <= rem >= BASE_W'(CHUNK_BYTES);
      if (out_load) begin
         out_ff               <= res_ff;
         out_ff.done_res      <= finished_ff;
         out_ff.bytes_written <= bytes_ff;
      end
   end

   // bin map words, registered read; the flag is the one the old contents belong to
   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
         rd_vld_ff  <= word_vld_ff[rd_addr];
      end
   end

endmodule

>>> hw/rtl/log_chunk_reassembly_tracker.sv
// ---------------------------------------------------------------------------
// log_chunk_reassembly_tracker
// Receive-side bin map tracker for a chunked log transfer with gap requests.
// ---------------------------------------------------------------------------
// flow: the front classifies a word, the two-entry queue holds it, then the sequencer
// handles it; the front takes no new word until the last has left it, and the sequencer
// takes none until its result is loaded for output; its gap search reads the 512-bin map
// one 32-bit word per cycle
// reset: synchronous; clears control state, marks every bin map word empty
// through per-word flags, so no clearing pass is needed
module log_chunk_reassembly_tracker
   import lcrt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [55:0]  req_tdata,   // pkt_offset[31:0], pkt_log_id[47:32], pkt_count[54:48]
   input  logic [1:0]   req_tuser,   // cmd[1:0]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [111:0] rsp_tdata,   // req_valid[0], req_log_id[16:1], req_offset[48:17],
                                     // req_length[64:49], req_retries[72:65],
                                     // done_res[73], bytes_written[105:74]
   output logic [2:0]   rsp_tuser,   // status[2:0]
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [3:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   logic [31:0]     log_size_ff;
   logic [15:0]     log_id_ff;
   logic            id_base_ff;
   logic            csr_wr;
   logic            f_valid, f_ready, q_valid, q_ready;
   lcrt_item_type   f_item, q_item;
   lcrt_result_type rsp_res;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         log_size_ff <= '0;
         log_id_ff   <= '0;
         id_base_ff  <= 1'b0;
      end else if (csr_wr) begin
         if (csr_paddr[3:2] == REG_LOG_SIZE) log_size_ff <= csr_pwdata;
         if (csr_paddr[3:2] == REG_LOG_ID) log_id_ff <= csr_pwdata[15:0];
         if (csr_paddr[3:2] == REG_ID_BASE) id_base_ff <= csr_pwdata[0];
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         REG_LOG_SIZE: csr_prdata = log_size_ff;
         REG_LOG_ID:   csr_prdata = 32'(log_id_ff);
         REG_ID_BASE:  csr_prdata = 32'(id_base_ff);
         default:      csr_prdata = '0;
      endcase
   end

   lcrt_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_cmd    (req_tuser),
      .in_offset (req_tdata[31:0]),
      .in_log_id (req_tdata[47:32]),
      .in_count  (req_tdata[54:48]),
      .log_size  (log_size_ff),
      .log_id    (log_id_ff),
      .id_base   (id_base_ff),
      .out_valid (f_valid),
      .out_ready (f_ready),
      .out_item  (f_item)
   );

   lcrt_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f_valid),
      .push_ready (f_ready),
      .push_item  (f_item),
      .pop_valid  (q_valid),
      .pop_ready  (q_ready),
      .pop_item   (q_item)
   );

   lcrt_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (q_valid),
      .in_ready  (q_ready),
      .in_item   (q_item),
      .log_size  (log_size_ff),
      .log_id    (log_id_ff),
      .id_base   (id_base_ff),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp       (rsp_res)
   );

   assign rsp_tuser = rsp_res.status;
   assign rsp_tdata = {6'b0, rsp_res.bytes_written, rsp_res.done_res, rsp_res.req_retries,
                       rsp_res.req_length, rsp_res.req_offset, rsp_res.req_log_id,
                       rsp_res.req_valid};

   // a request never goes out together with completion
   a_req_not_done: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_res.req_valid |-> !rsp_res.done_res)
      else $error("request issued while complete");

   // rejected packets never carry a request
   a_req_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_res.req_valid |->
         (rsp_res.status == ST_OK || rsp_res.status == ST_BIN_OOR ||
          rsp_res.status == ST_OTHER))
      else $error("request on a rejected word");

   // a request never spans more than one chunk
   a_req_len: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_res.req_valid |-> rsp_res.req_length <= 16'(CHUNK_BYTES))
      else $error("request longer than a chunk");

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the log chunk reassembly tracker: queued packets,
// starts and ticks are driven in bursts, a bin-map predictor runs on every
// accepted word and each result word is compared against its expectation.
// ----------------------------------------------------------------------------
module tb_top;
   import lcrt_pkg::*;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [31:0] offs;
      logic [15:0] pid;
      logic [6:0]  cnt;
   } log_word_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [55:0]  req_tdata;   // pkt_offset[31:0], pkt_log_id[47:32], pkt_count[54:48]
   logic [1:0]   req_tuser;   // cmd[1:0]
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [111:0] rsp_tdata;   // req_valid[0], req_log_id[16:1], req_offset[48:17],
                              // req_length[64:49], req_retries[72:65],
                              // done_res[73], bytes_written[105:74]
   logic [2:0]   rsp_tuser;   // status[2:0]
   logic         csr_psel;
   logic         csr_penable;
   logic         csr_pwrite;
   logic [3:0]   csr_paddr;
   logic [31:0]  csr_pwdata;
   logic [31:0]  csr_prdata;
   logic         csr_pready;

   log_chunk_reassembly_tracker DUT (.*);

   localparam int IDLE_LIMIT = 4000;

   log_word_type    pending_words[$];
   lcrt_result_type expected_results[$];
   log_word_type    cur_word;
   bit              drv_busy;
   int              errors;
   int              item_count;
   int              idle_cycles;
   int              cyc;
   int              burst_left;
   int              gap_left;

   // predictor copy of configuration and state
   logic [31:0]     cfg_size;
   logic [15:0]     cfg_id;
   logic            cfg_base;
   logic [511:0]    bin_held;
   logic [16:0]     chunk_idx;
   int unsigned     chunk_bins;
   logic [7:0]      retries;
   logic [31:0]     byte_sum;
   logic            xfer_done;
   lcrt_result_type pred;
   lcrt_result_type got;

   initial clock = 1'b0;
   always #2 clock = ~clock;

   function automatic int unsigned bins_of_chunk(logic [16:0] c);
      longint unsigned base, n;
      base = longint'(c) * CHUNK_BYTES;
      if (longint'(cfg_size) <= base) return 0;
      n = (longint'(cfg_size) - base + BIN_BYTES - 1) / BIN_BYTES;
      return (n > BINS_PER_CHUNK) ? BINS_PER_CHUNK : int'(n);
   endfunction

   function automatic bit chunk_complete();
      for (int unsigned i = 0; i < chunk_bins; i++) begin
         if (!bin_held[i]) return 0;
      end
      return 1;
   endfunction

   function automatic bit log_complete();
      longint unsigned nch;
      nch = (longint'(cfg_size) + CHUNK_BYTES - 1) / CHUNK_BYTES;
      return chunk_complete() && (longint'(chunk_idx) + 1 == nch);
   endfunction

   function automatic void advance_chunk();
      chunk_idx  = chunk_idx + 17'd1;
      bin_held   = '0;
      chunk_bins = bins_of_chunk(chunk_idx);
   endfunction

   function automatic void issue_request(longint unsigned o, longint unsigned l,
                                         logic [7:0] rt);
      pred.req_valid   = 1'b1;
      pred.req_log_id  = cfg_id + {15'd0, cfg_base};
      pred.req_offset  = o[31:0];
      pred.req_length  = l[15:0];
      pred.req_retries = rt;
   endfunction

   function automatic void request_gap();
      int unsigned first, last;
      if (log_complete()) begin
         xfer_done = 1'b1;
         return;
      end
      if (chunk_complete()) advance_chunk();
      if (retries != 8'hFF) retries = retries + 8'd1;
      first = 0;
      while (first < chunk_bins && bin_held[first]) first++;
      last = first;
      while (last < chunk_bins && !bin_held[last]) last++;
      issue_request(longint'(chunk_idx) * CHUNK_BYTES + longint'(first) * BIN_BYTES,
                    longint'(last - first) * BIN_BYTES, retries);
   endfunction

   function automatic void predict_word(log_word_type w);
      longint unsigned chunk, rel;
      int unsigned     bin;
      logic [15:0]     id_diff;
      pred = '0;
      pred.status = ST_OTHER;
      if (w.cmd == CMD_START) begin
         bin_held   = '0;
         chunk_idx  = '0;
         retries    = '0;
         byte_sum   = '0;
         chunk_bins = bins_of_chunk(17'd0);
         if (cfg_size == 0) begin
            xfer_done = 1'b1;
         end else begin
            xfer_done = 1'b0;
            issue_request(0, longint'(chunk_bins) * BIN_BYTES, 8'd0);
         end
      end else if (w.cmd == CMD_TICK) begin
         if (!xfer_done) request_gap();
      end else if (w.cmd == CMD_DATA && !xfer_done) begin
         chunk   = longint'(w.offs) / CHUNK_BYTES;
         id_diff = w.pid - {15'd0, cfg_base};
         if (id_diff != cfg_id) begin
            pred.status = ST_BAD_ID;
         end else if (w.offs % BIN_BYTES != 0) begin
            pred.status = ST_MISALIGN;
         end else if (w.offs > cfg_size) begin
            pred.status = ST_BEYOND;
         end else if (chunk != longint'(chunk_idx)) begin
            pred.status = ST_BAD_CHNK;
         end else begin
            rel = (longint'(w.offs) - chunk * CHUNK_BYTES) / BIN_BYTES;
            bin = int'(rel);
            if (bin >= chunk_bins || bin >= BINS_PER_CHUNK) begin
               pred.status = ST_BIN_OOR;
            end else begin
               pred.status = ST_OK;
               bin_held[bin] = 1'b1;
            end
            byte_sum = byte_sum + {25'd0, w.cnt};
            retries  = '0;
            if (log_complete()) begin
               xfer_done = 1'b1;
            end else if (chunk_complete()) begin
               advance_chunk();
               issue_request(longint'(chunk_idx) * CHUNK_BYTES,
                             longint'(chunk_bins) * BIN_BYTES, 8'd0);
            end else if (bin + 1 < chunk_bins && bin_held[bin + 1]) begin
               request_gap();
            end
         end
      end
      pred.done_res      = xfer_done;
      pred.bytes_written = byte_sum;
      expected_results.push_back(pred);
   endfunction

   // acceptance, prediction and checking at the rising edge
   always @(posedge clock) begin
      cyc <= cyc + 1;
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_psel && csr_penable))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (req_tvalid && req_tready) begin
            predict_word(cur_word);
            drv_busy = 1'b0;
         end
         if (rsp_tvalid && rsp_tready) begin
            got.status        = rsp_tuser;
            got.req_valid     = rsp_tdata[0];
            got.req_log_id    = rsp_tdata[16:1];
            got.req_offset    = rsp_tdata[48:17];
            got.req_length    = rsp_tdata[64:49];
            got.req_retries   = rsp_tdata[72:65];
            got.done_res      = rsp_tdata[73];
            got.bytes_written = rsp_tdata[105:74];
            if (expected_results.size() == 0) begin
               $display("%0t unexpected word: st=%0d rv=%0d", $time, got.status,
                        got.req_valid);
               errors++;
            end else begin
               pred = expected_results.pop_front();
               if (got !== pred) begin
                  $display("%0t mismatch exp st=%0d rv=%0d id=%h off=%h len=%h rt=%h dn=%0d bw=%h",
                           $time, pred.status, pred.req_valid, pred.req_log_id,
                           pred.req_offset, pred.req_length, pred.req_retries,
                           pred.done_res, pred.bytes_written);
                  $display("%0t          got st=%0d rv=%0d id=%h off=%h len=%h rt=%h dn=%0d bw=%h",
                           $time, got.status, got.req_valid, got.req_log_id,
                           got.req_offset, got.req_length, got.req_retries,
                           got.done_res, got.bytes_written);
                  errors++;
               end
            end
         end
      end
   end

   // sender in bursts, receiver on a rotating stall pattern
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         rsp_tready <= 1'b0;
      end else begin
         if (!drv_busy) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_words.size() > 0) begin
               cur_word = pending_words.pop_front();
               drv_busy = 1'b1;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 30);
                  gap_left   = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12);
               end
            end
         end
         req_tvalid <= drv_busy;
         req_tdata  <= {1'b0, cur_word.cnt, cur_word.pid, cur_word.offs};
         req_tuser  <= cur_word.cmd;
         case ((cyc / 1500) % 4)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= ($urandom_range(0, 3) != 0);
            2: rsp_tready <= ((cyc % 7) < 3);
            default: rsp_tready <= 1'($urandom_range(0, 1));
         endcase
      end
   end

   always @(posedge clock) begin
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb_top: errors");
         $finish;
      end
   end

   task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= val;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         REG_LOG_SIZE: cfg_size = val;
         REG_LOG_ID:   cfg_id   = val[15:0];
         default:      cfg_base = val[0];
      endcase
   endtask

   task automatic set_log(input logic [31:0] size, input logic [15:0] id, input logic base);
      write_reg(REG_LOG_SIZE, size);
      write_reg(REG_LOG_ID, {16'd0, id});
      write_reg(REG_ID_BASE, {31'd0, base});
   endtask

   task automatic push(input logic [1:0] c, input logic [31:0] o, input logic [15:0] p,
                       input logic [6:0] n);
      log_word_type w;
      w = '{cmd: c, offs: o, pid: p, cnt: n};
      pending_words.push_back(w);
      item_count++;
   endtask

   task automatic push_noise(input logic [15:0] wid);
      logic [1:0]  c;
      logic [31:0] o;
      c = ($urandom_range(0, 19) == 0) ? CMD_START : 2'($urandom_range(1, 3));
      o = ($urandom_range(0, 1) == 0) ? $urandom : 32'($urandom_range(0, 1200) * BIN_BYTES);
      push(c, o, ($urandom_range(0, 2) == 0) ? 16'($urandom) : wid,
           7'($urandom_range(0, 90)));
   endtask

   // start, then the bins of each chunk in a loosely shuffled order with ticks, noise and repeats mixed in, then a tick
   task automatic send_transfer(input longint unsigned size, input logic [15:0] wid,
                                input int cap);
      longint unsigned nbins_all, nchunks;
      int unsigned     ord[BINS_PER_CHUNK];
      int unsigned     nbc, j, tmp, roll;
      int              sent;
      logic [31:0]     o;
      nbins_all = (size + BIN_BYTES - 1) / BIN_BYTES;
      nchunks   = (size + CHUNK_BYTES - 1) / CHUNK_BYTES;
      sent      = 0;
      push(CMD_START, $urandom, 16'($urandom), 7'($urandom_range(0, 90)));
      for (longint unsigned c = 0; c < nchunks && sent < cap; c++) begin
         nbc = ((nbins_all - c * BINS_PER_CHUNK) > BINS_PER_CHUNK) ? BINS_PER_CHUNK
               : int'(nbins_all - c * BINS_PER_CHUNK);
         for (int unsigned i = 0; i < nbc; i++) ord[i] = i;
         for (int unsigned i = 0; i < nbc; i++) begin
            if ($urandom_range(0, 4) == 0) begin
               j = $urandom_range(i, (i + 4 < nbc) ? i + 4 : nbc - 1);
               tmp = ord[i]; ord[i] = ord[j]; ord[j] = tmp;
            end
         end
         for (int unsigned i = 0; i < nbc && sent < cap; i++) begin
            roll = $urandom_range(0, 99);
            if (roll < 4) push(CMD_TICK, $urandom, 16'($urandom), 7'($urandom_range(0, 90)));
            else if (roll < 10) push_noise(wid);
            o = 32'((c * BINS_PER_CHUNK + ord[i]) * BIN_BYTES);
            push(CMD_DATA, o, wid, 7'($urandom_range(0, 90)));
            if (roll >= 97) push(CMD_DATA, o, wid, 7'($urandom_range(0, 90)));
            sent++;
         end
      end
      push(CMD_TICK, $urandom, 16'($urandom), 7'd0);
   endtask

   task automatic wait_idle();
      while (pending_words.size() != 0 || drv_busy || expected_results.size() != 0)
         @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   initial begin
      logic [15:0] wid;
      int          roll;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = '0;
      rsp_tready  = 1'b0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      cur_word    = '0;
      drv_busy    = 1'b0;
      errors      = 0;
      item_count  = 0;
      idle_cycles = 0;
      cyc         = 0;
      burst_left  = 0;
      gap_left    = 0;
      cfg_size    = '0;
      cfg_id      = '0;
      cfg_base    = 1'b0;
      bin_held    = '0;
      chunk_idx   = '0;
      chunk_bins  = 0;
      retries     = '0;
      byte_sum    = '0;
      xfer_done   = 1'b1;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // idle after reset, then a zero-size log
      push(CMD_DATA, 32'd0, 16'd0, 7'd90);
      push(CMD_TICK, 32'd0, 16'd0, 7'd0);
      push(CMD_UNUSED, 32'hFFFF_FFFF, 16'hFFFF, 7'h7F);
      push(CMD_START, 32'd0, 16'd0, 7'd0);
      push(CMD_DATA, 32'd0, 16'd0, 7'd10);
      wait_idle();

      // eleven exact bins, remote counts from one
      set_log(32'd990, 16'd5, 1'b1);
      push(CMD_START, 32'd0, 16'd0, 7'd0);
      push(CMD_DATA, 32'd0, 16'd5, 7'd90);
      push(CMD_DATA, 32'd1, 16'd6, 7'd90);
      push(CMD_DATA, 32'd1080, 16'd6, 7'd90);
      push(CMD_DATA, 32'd990, 16'd6, 7'd90);
      push(CMD_DATA, 32'd0, 16'd6, 7'd0);
      push(CMD_DATA, 32'd180, 16'd6, 7'd64);
      push(CMD_DATA, 32'd90, 16'd6, 7'd1);
      push(CMD_UNUSED, 32'd0, 16'd6, 7'd0);
      push(CMD_TICK, 32'd0, 16'd0, 7'd0);
      for (int k = 3; k < 11; k++) push(CMD_DATA, 32'(k * BIN_BYTES), 16'd6, 7'd90);
      push(CMD_DATA, 32'd0, 16'd6, 7'd90);
      push(CMD_TICK, 32'd0, 16'd0, 7'd0);
      wait_idle();

      // maximum size, id at the top of its range
      set_log(32'hFFFF_FFFF, 16'hFFFF, 1'b0);
      push(CMD_START, 32'd0, 16'd0, 7'd0);
      push(CMD_DATA, CHUNK_BYTES, 16'hFFFF, 7'd90);
      push(CMD_DATA, 32'hFFFF_FFFF, 16'hFFFF, 7'd90);
      push(CMD_DATA, 32'd0, 16'hFFFF, 7'd90);
      push(CMD_TICK, 32'd0, 16'd0, 7'd0);
      wait_idle();

      // one full chunk then a short one, wire id wraps to zero
      set_log(32'(CHUNK_BYTES + 180), 16'hFFFF, 1'b1);
      send_transfer(64'(CHUNK_BYTES + 180), 16'h0000, 600);
      wait_idle();

      while (item_count < 1400) begin
         roll = $urandom_range(0, 99);
         if (roll < 8) begin
            write_reg(REG_LOG_SIZE, 32'd0);
            push(CMD_START, $urandom, 16'($urandom), 7'd0);
            repeat (3) push_noise(cfg_id + {15'd0, cfg_base});
         end else if (roll < 20) begin
            // size change in the middle of a transfer
            write_reg(REG_LOG_SIZE, $urandom_range(1, 5000));
            wid = cfg_id + {15'd0, cfg_base};
            repeat (10) begin
               if ($urandom_range(0, 2) == 0) push(CMD_TICK, $urandom, 16'($urandom), 7'd0);
               else push(CMD_DATA, 32'($urandom_range(0, 60) * BIN_BYTES), wid,
                         7'($urandom_range(0, 90)));
            end
         end else if (roll < 32) begin
            set_log($urandom, 16'($urandom), 1'($urandom_range(0, 1)));
            wid = cfg_id + {15'd0, cfg_base};
            push(CMD_START, $urandom, 16'($urandom), 7'd0);
            repeat (15) begin
               if ($urandom_range(0, 1) == 0) push_noise(wid);
               else push(CMD_DATA, 32'($urandom_range(0, 600) * BIN_BYTES), wid,
                         7'($urandom_range(0, 90)));
            end
         end else begin
            set_log(($urandom_range(0, 9) < 7) ? $urandom_range(1, 3000)
                    : $urandom_range(1, 20000), 16'($urandom), 1'($urandom_range(0, 1)));
            send_transfer(64'(cfg_size), cfg_id + {15'd0, cfg_base}, 200);
         end
         wait_idle();
      end

      repeat (40) @(posedge clock);
      if (errors == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule

>>> log_chunk_reassembly_tracker.f
hw/rtl/lcrt_pkg.sv
hw/rtl/lcrt_front.sv
hw/rtl/lcrt_queue.sv
hw/rtl/lcrt_back.sv
hw/rtl/log_chunk_reassembly_tracker.sv
verif/tb_top.sv
